// File: hdl/prb_nack_pkg.sv
package prb_nack_pkg;

  localparam int WINDOW      = 32;
  localparam int HANDLE_BITS = 8;
  localparam int SEQ_BITS    = 32;
  localparam int IDX_W       = $clog2(WINDOW);
  localparam int TDATA_W     = ((SEQ_BITS + HANDLE_BITS + 7) / 8) * 8;

  // Input item kinds on s_tuser.
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // Result kinds on m_tuser.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_NACK    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL_READ,
    ST_REL_EMIT,
    ST_NACK_SCAN,
    ST_NACK_LAST
  } prb_state_t;

  typedef struct packed {
    logic ready;
    logic arrive;
    logic tick_start;
    logic rel_read;
    logic deliver;
    logic scan_step;
    logic nack_last;
  } prb_ctrl_t;

  typedef struct packed {
    logic out_ok;
    logic cur_valid;
    logic nxt_valid;
    logic scan_end;
    logic scan_missing;
    logic pend_valid;
  } prb_status_t;

endpackage

// File: hdl/prb_nack_ctrl.sv
module prb_nack_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tuser,
  input  prb_nack_pkg::prb_status_t status,
  output prb_nack_pkg::prb_ctrl_t   ctrl,
  output prb_nack_pkg::prb_state_t  state
);
  import prb_nack_pkg::*;

  prb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        ctrl.ready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == KIND_TICK) begin
            ctrl.tick_start = 1'b1;
            state_next      = ST_NACK_SCAN;
          end else begin
            ctrl.arrive = 1'b1;
            state_next  = ST_REL_READ;
          end
        end
      end
      ST_REL_READ: begin
        ctrl.rel_read = 1'b1;
        state_next    = ST_REL_EMIT;
      end
      ST_REL_EMIT: begin
        if (!status.cur_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_ok) begin
          ctrl.deliver = 1'b1;
          state_next   = status.nxt_valid ? ST_REL_READ : ST_IDLE;
        end
      end
      ST_NACK_SCAN: begin
        if (status.scan_end) begin
          state_next = ST_NACK_LAST;
        end else if (!(status.scan_missing && status.pend_valid && !status.out_ok)) begin
          ctrl.scan_step = 1'b1;
        end
      end
      ST_NACK_LAST: begin
        if (!status.pend_valid) begin
          state_next = ST_IDLE;
        end else if (status.out_ok) begin
          ctrl.nack_last = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/prb_nack_dp.sv
module prb_nack_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  prb_nack_pkg::prb_ctrl_t              ctrl,
  input  logic                                 s_tvalid,
  input  logic [prb_nack_pkg::TDATA_W-1:0]     s_tdata,
  output prb_nack_pkg::prb_status_t            status,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [prb_nack_pkg::TDATA_W-1:0]     m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);
  import prb_nack_pkg::*;

  logic [HANDLE_BITS-1:0] slot_handle [WINDOW];
  logic [WINDOW-1:0]      slot_valid;
  logic [SEQ_BITS-1:0]    next_expected;
  logic [SEQ_BITS-1:0]    highest_seen;

  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   cur_valid;
  logic                   nxt_valid;
  logic [IDX_W-1:0]       gap_lo;
  logic                   gap_big;
  logic [IDX_W-1:0]       scan_i;
  logic                   pend_valid;
  logic [SEQ_BITS-1:0]    pend_seq;

  logic                   out_valid;
  logic                   out_kind;
  logic [SEQ_BITS-1:0]    out_seq;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_last;

  logic                   accept;
  logic [SEQ_BITS-1:0]    seq_in;
  logic [HANDLE_BITS-1:0] handle_in;
  logic [SEQ_BITS-1:0]    seq_dist;
  logic [SEQ_BITS-1:0]    hdist;
  logic                   in_window;
  logic                   new_highest;
  logic [IDX_W-1:0]       ne_idx;
  logic [IDX_W-1:0]       scan_idx;
  logic                   missing;
  logic                   out_ok;
  logic                   emit_pend;

  assign accept    = s_tvalid && ctrl.ready;
  assign seq_in    = s_tdata[SEQ_BITS-1:0];
  assign handle_in = s_tdata[SEQ_BITS+HANDLE_BITS-1:SEQ_BITS];
  assign seq_dist  = seq_in - next_expected;
  assign hdist     = highest_seen - next_expected;
  assign in_window = (seq_dist[SEQ_BITS-1:IDX_W] == '0);
  // The stored highest is stale once everything up to it has been delivered.
  assign new_highest = (hdist[SEQ_BITS-1:IDX_W] != '0) ||
                       (seq_dist[IDX_W-1:0] > hdist[IDX_W-1:0]);
  assign ne_idx    = next_expected[IDX_W-1:0];
  assign scan_idx  = ne_idx + scan_i;
  assign missing   = !slot_valid[scan_idx];
  assign out_ok    = !out_valid || m_tready;
  assign emit_pend = ctrl.scan_step && missing && pend_valid;

  assign status.out_ok       = out_ok;
  assign status.cur_valid    = cur_valid;
  assign status.nxt_valid    = nxt_valid;
  assign status.scan_end     = gap_big || (scan_i == gap_lo);
  assign status.scan_missing = missing;
  assign status.pend_valid   = pend_valid;

  // Handle store: written on an in-window arrival, read one slot per release step.
  always_ff @(posedge clk) begin
    if (accept && ctrl.arrive && in_window) begin
      slot_handle[seq_in[IDX_W-1:0]] <= handle_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rel_read) begin
      rd_handle <= slot_handle[ne_idx];
      cur_valid <= slot_valid[ne_idx];
      nxt_valid <= slot_valid[IDX_W'(ne_idx + 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      next_expected <= '0;
      highest_seen  <= '0;
    end else begin
      if (accept && ctrl.arrive && in_window) begin
        slot_valid[seq_in[IDX_W-1:0]] <= 1'b1;
        if (new_highest) begin
          highest_seen <= seq_in;
        end
      end
      if (ctrl.deliver) begin
        slot_valid[ne_idx] <= 1'b0;
        next_expected      <= next_expected + 1'b1;
      end
    end
  end

  // NACK scan: a missing sequence is held until the next one is found, so that
  // the final one can be marked last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept && ctrl.tick_start) begin
      pend_valid <= 1'b0;
    end else if (ctrl.scan_step && missing) begin
      pend_valid <= 1'b1;
    end else if (ctrl.nack_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ctrl.tick_start) begin
      gap_lo  <= hdist[IDX_W-1:0];
      gap_big <= (hdist[SEQ_BITS-1:IDX_W] != '0);
      scan_i  <= '0;
    end else if (ctrl.scan_step) begin
      scan_i <= scan_i + 1'b1;
      if (missing) begin
        pend_seq <= next_expected + SEQ_BITS'(scan_i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.deliver || emit_pend || ctrl.nack_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.deliver) begin
      out_kind   <= KIND_DELIVER;
      out_seq    <= next_expected;
      out_handle <= rd_handle;
      out_last   <= !nxt_valid;
    end else if (emit_pend || ctrl.nack_last) begin
      out_kind   <= KIND_NACK;
      out_seq    <= pend_seq;
      out_handle <= '0;
      out_last   <= ctrl.nack_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = TDATA_W'({out_handle, out_seq});

endmodule

// File: hdl/packet_reorder_buffer_nack_unit.sv
// Channel  Direction  Transfer payload
// s_*      in         tuser: kind; tdata: seq, pkt_handle
// m_*      out        tuser: kind_res; tdata: seq_res, pkt_handle_res; tlast: last
//
// An arrival releases the packets that are now in order from next_expected: each
// release reads the handle store once, then loads the output register.
// A tick scans one window slot per cycle while the output is not stalled, up to highest_seen;
// when highest_seen is not inside the window ahead of next_expected it scans no slot.
// Reset clears the valid map, the sequence counters and the output valid flag.
// A stalled output stops the release or scan until the result is taken.
module packet_reorder_buffer_nack_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [prb_nack_pkg::TDATA_W-1:0]     s_tdata,  // seq, pkt_handle
  input  logic                                 s_tuser,  // kind
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [prb_nack_pkg::TDATA_W-1:0]     m_tdata,  // seq_res, pkt_handle_res
  output logic                                 m_tuser,  // kind_res
  output logic                                 m_tlast
);
  import prb_nack_pkg::*;

  prb_ctrl_t   ctrl;
  prb_status_t status;
  prb_state_t  state;

  prb_nack_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .status   (status),
    .ctrl     (ctrl),
    .state    (state)
  );

  prb_nack_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign s_tready = ctrl.ready;

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.deliver || ctrl.scan_step && status.scan_missing && status.pend_valid ||
     ctrl.nack_last) |-> status.out_ok)
    else $error("result loaded while output register is occupied");

  // Input is taken only when the previous item's work is finished.
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("input ready outside idle");

  // A NACK never carries a buffer handle.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_NACK) |-> m_tdata[TDATA_W-1:SEQ_BITS] == '0)
    else $error("nack result with nonzero handle");

  // A delivery is always followed by the next read step or by a return to idle.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.deliver |=> (state == ST_REL_READ || state == ST_IDLE))
    else $error("release step sequencing broken");

endmodule
